// File: rtl/bdeq_pkg.sv
package bdeq_pkg;

   // Defaults for the top-level parameters.
   localparam int DEPTH_DEFAULT     = 8;
   localparam int WORD_BITS_DEFAULT = 32;

   // Fixed widths of the channel fields.
   localparam int KIND_BITS   = 2;
   localparam int STATUS_BITS = 2;
   localparam int DATA_BITS   = 32;
   localparam int CAP_BITS    = 4;

   // Capacity limit after reset.
   localparam logic [CAP_BITS-1:0] CAP_RESET = 4'd5;

   // Operation codes.
   localparam logic [KIND_BITS-1:0] KIND_PUSH = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_POP  = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_DUMP = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_RSVD = 2'd3;

   // Result status codes.
   localparam logic [STATUS_BITS-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STAT_OVERFLOW  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STAT_UNDERFLOW = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic push_ok;
      logic push_ovf;
      logic pop_ok;
      logic underflow;
      logic dump_start;
      logic dump_next;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic full;
      logic empty;
      logic last;
   } sts_type;

endpackage

// File: rtl/bdeq_if.sv
interface bdeq_req_if;
   logic                           valid;
   logic                           ready;
   logic [bdeq_pkg::KIND_BITS-1:0] kind;
   logic                           end_sel;
   logic signed [bdeq_pkg::DATA_BITS-1:0] push_value;

   modport source (output valid, kind, end_sel, push_value, input ready);
   modport sink   (input valid, kind, end_sel, push_value, output ready);
endinterface

interface bdeq_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [bdeq_pkg::STATUS_BITS-1:0] status;
   logic signed [bdeq_pkg::DATA_BITS-1:0] word_out;
   logic                             last;

   modport source (output valid, status, word_out, last, input ready);
   modport sink   (input valid, status, word_out, last, output ready);
endinterface

interface bdeq_csr_if;
   logic                          valid;
   logic                          ready;
   logic [bdeq_pkg::CAP_BITS-1:0] capacity_limit;

   modport source (output valid, capacity_limit, input ready);
   modport sink   (input valid, capacity_limit, output ready);
endinterface

// File: rtl/bdeq_ctrl.sv
module bdeq_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic [bdeq_pkg::KIND_BITS-1:0] req_kind,
   output logic                           req_ready,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   input  bdeq_pkg::sts_type              sts,
   output bdeq_pkg::cmd_type              cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_RESP = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;
   logic is_push;
   logic is_pop;
   logic is_dump;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign accept    = req_ready && req_valid;

   assign is_push = (req_kind == bdeq_pkg::KIND_PUSH);
   assign is_pop  = (req_kind == bdeq_pkg::KIND_POP);
   assign is_dump = (req_kind == bdeq_pkg::KIND_DUMP);

   always_comb begin
      cmd.push_ok    = accept && is_push && !sts.full;
      cmd.push_ovf   = accept && is_push && sts.full;
      cmd.pop_ok     = accept && is_pop && !sts.empty;
      cmd.underflow  = accept && (is_pop || is_dump) && sts.empty;
      cmd.dump_start = accept && is_dump && !sts.empty;
      // Advance a dump walk once the current element has been taken.
      cmd.dump_next  = rsp_valid && rsp_ready && !sts.last;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_kind != bdeq_pkg::KIND_RSVD)) state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready && sts.last) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $countones(cmd) <= 1)
      else $error("more than one datapath command in a cycle");

   a_resp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped before it was taken");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a result is pending");

endmodule

// File: rtl/bdeq_datapath.sv
module bdeq_datapath #(
   parameter int DEPTH     = bdeq_pkg::DEPTH_DEFAULT,
   parameter int WORD_BITS = bdeq_pkg::WORD_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_end_sel,
   input  logic signed [bdeq_pkg::DATA_BITS-1:0] req_push_value,
   input  logic                                csr_valid,
   input  logic [bdeq_pkg::CAP_BITS-1:0]       csr_capacity_limit,
   output logic                                csr_ready,
   output logic [bdeq_pkg::STATUS_BITS-1:0]    rsp_status,
   output logic signed [bdeq_pkg::DATA_BITS-1:0] rsp_word_out,
   output logic                                rsp_last,
   input  bdeq_pkg::cmd_type                   cmd,
   output bdeq_pkg::sts_type                   sts
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WORD_BITS-1:0] slots_ff [DEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;

   logic [IW-1:0]                      front_ff, front_in;
   logic [CW-1:0]                      count_ff, count_in;
   logic [bdeq_pkg::CAP_BITS-1:0]      cap_ff;
   logic [CW-1:0]                      walk_ff, walk_in;
   logic                               dir_ff, dir_in;
   logic [bdeq_pkg::STATUS_BITS-1:0]   status_ff, status_in;
   logic                               last_ff, last_in;
   logic                               from_mem_ff, from_mem_in;
   logic                               load;

   logic                 rd_en;
   logic [CW-1:0]        rd_off;
   logic [IW-1:0]        rd_addr;
   logic                 wr_en;
   logic [IW-1:0]        wr_addr;
   logic [WORD_BITS-1:0] wr_data;
   logic [IW-1:0]        front_dec;
   logic [IW-1:0]        front_inc;
   logic [bdeq_pkg::DATA_BITS-1:0] word_ext;

   function automatic logic [IW-1:0] ring_pos(input logic [IW-1:0] base,
                                              input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = (CW+1)'(base) + (CW+1)'(off);
      if (sum >= (CW+1)'(DEPTH)) sum = sum - (CW+1)'(DEPTH);
      return sum[IW-1:0];
   endfunction

   assign csr_ready = 1'b1;

   // Full covers both the register limit and the physical depth.
   assign sts.full  = (32'(count_ff) >= 32'(cap_ff)) || (count_ff == CW'(DEPTH));
   assign sts.empty = (count_ff == '0);
   assign sts.last  = last_ff;

   assign front_dec = (front_ff == '0) ? IW'(DEPTH - 1) : front_ff - 1'b1;
   assign front_inc = (front_ff == IW'(DEPTH - 1)) ? '0 : front_ff + 1'b1;

   always_comb begin
      walk_in = walk_ff;
      dir_in  = dir_ff;
      if (cmd.dump_start) begin
         walk_in = '0;
         dir_in  = req_end_sel;
      end else if (cmd.dump_next) begin
         walk_in = walk_ff + 1'b1;
      end
   end

   always_comb begin
      rd_en = cmd.pop_ok || cmd.dump_start || cmd.dump_next;
      if (cmd.pop_ok) begin
         rd_off = req_end_sel ? count_ff - 1'b1 : '0;
      end else begin
         rd_off = dir_in ? count_ff - 1'b1 - walk_in : walk_in;
      end
      rd_addr = ring_pos(front_ff, rd_off);
   end

   always_comb begin
      wr_en   = cmd.push_ok;
      wr_addr = req_end_sel ? ring_pos(front_ff, count_ff) : front_dec;
      wr_data = WORD_BITS'($unsigned(req_push_value));
   end

   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      if (cmd.push_ok) begin
         count_in = count_ff + 1'b1;
         if (!req_end_sel) front_in = front_dec;
      end else if (cmd.pop_ok) begin
         count_in = count_ff - 1'b1;
         if (!req_end_sel) front_in = front_inc;
      end
   end

   always_comb begin
      load        = cmd.push_ok || cmd.push_ovf || cmd.underflow || rd_en;
      status_in   = bdeq_pkg::STAT_OK;
      last_in     = 1'b1;
      from_mem_in = rd_en;
      priority if (cmd.push_ovf) begin
         status_in = bdeq_pkg::STAT_OVERFLOW;
      end else if (cmd.underflow) begin
         status_in = bdeq_pkg::STAT_UNDERFLOW;
      end else if (cmd.dump_start || cmd.dump_next) begin
         last_in = (walk_in == count_ff - 1'b1);
      end else begin
         status_in = bdeq_pkg::STAT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) slots_ff[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= slots_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
         cap_ff   <= bdeq_pkg::CAP_RESET;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
         if (csr_valid) cap_ff <= csr_capacity_limit;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff <= walk_in;
      dir_ff  <= dir_in;
      if (load) begin
         status_ff   <= status_in;
         last_ff     <= last_in;
         from_mem_ff <= from_mem_in;
      end
   end

   generate
      if (WORD_BITS >= bdeq_pkg::DATA_BITS) begin : g_wide
         assign word_ext = rd_data_ff[bdeq_pkg::DATA_BITS-1:0];
      end else begin : g_narrow
         assign word_ext = {{(bdeq_pkg::DATA_BITS - WORD_BITS){rd_data_ff[WORD_BITS-1]}},
                            rd_data_ff};
      end
   endgenerate

   assign rsp_status   = status_ff;
   assign rsp_last     = last_ff;
   assign rsp_word_out = from_mem_ff ? $signed(word_ext) : '0;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("element count beyond depth");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_ok |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("pop did not reduce the count");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      cmd.push_ok |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push did not raise the count");

   a_dump_stable: assert property (@(posedge clock) disable iff (reset)
      cmd.dump_next |=> ($stable(count_ff) && $stable(front_ff)))
      else $error("dump walk changed the queue");

endmodule

// File: rtl/bounded_double_ended_queue.sv
// Bounded double-ended queue of signed words held in a ring buffer of DEPTH
// slots. Each request transaction is a push, a pop or a dump aimed at the front
// or the back; a push onto a queue holding capacity_limit elements (capped at
// DEPTH) reports overflow, and a pop or dump of an empty queue reports
// underflow. Every request yields exactly one response transaction with last
// set, except a dump of n elements, which yields n responses with last on the
// final one, and the unused kind code, which is taken and yields nothing. A
// request is taken and its first response is presented in the next cycle
// from registers; the request side stays not ready until the final response
// of that request has been taken. A dump streams one element per cycle while
// the response side is ready, limited by the single registered read port of
// the slot memory. The storage needs no clearing after reset. The capacity
// limit is written through the csr channel, which is always ready and must
// only be used while no request is in progress.
module bounded_double_ended_queue #(
   parameter int DEPTH     = bdeq_pkg::DEPTH_DEFAULT,
   parameter int WORD_BITS = bdeq_pkg::WORD_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   bdeq_req_if.sink   req_bus,
   bdeq_rsp_if.source rsp_bus,
   bdeq_csr_if.sink   csr_bus
);

   // Commands and status between the controller and the datapath.
   bdeq_pkg::cmd_type cmd;
   bdeq_pkg::sts_type sts;

   // The controller owns the request and response handshakes and decides what each transaction does.
   bdeq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_kind  (req_bus.kind),
      .req_ready (req_bus.ready),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the slots, the ring pointers, the limit register and
   // the response registers.
   bdeq_datapath #(
      .DEPTH     (DEPTH),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_end_sel        (req_bus.end_sel),
      .req_push_value     (req_bus.push_value),
      .csr_valid          (csr_bus.valid),
      .csr_capacity_limit (csr_bus.capacity_limit),
      .csr_ready          (csr_bus.ready),
      .rsp_status         (rsp_bus.status),
      .rsp_word_out       (rsp_bus.word_out),
      .rsp_last           (rsp_bus.last),
      .cmd                (cmd),
      .sts                (sts)
   );

endmodule
